// ===== hdl/xrgf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xrgf_pkg: shared types and constants of the random grid fill
// Field widths of the channels, register indexes and generator constants.
// ----------------------------------------------------------------------------
package xrgf_pkg;

  localparam int unsigned SpeciesW = 8;
  localparam int unsigned IndexW   = 24;
  localparam int unsigned CountW   = 8;
  localparam int unsigned EdgeW    = 9;
  localparam int unsigned EdgeSqW  = 17;
  localparam int unsigned StateW   = 32;
  localparam int unsigned DensityW = 33;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 33;

  typedef logic [SpeciesW-1:0] species_t;
  typedef logic [IndexW-1:0]   index_t;
  typedef logic [StateW-1:0]   rng_state_t;
  typedef logic [DensityW-1:0] density_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SEED_VALUE       = 2'd0,
    CFG_DENSITY_FRACTION = 2'd1,
    CFG_GRID_SIZE        = 2'd2
  } cfg_idx_e;

  localparam rng_state_t SeedOffset = 32'd987654321;
  localparam rng_state_t DrawFlip   = 32'h8000_0000;

endpackage

// ===== hdl/xrgf_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xrgf_in_if: input channel of the random grid fill
// Valid/ready channel that carries the restart request of one tick.
// ----------------------------------------------------------------------------
interface xrgf_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

// ===== hdl/xrgf_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xrgf_out_if: result channel of the random grid fill
// Valid/ready channel that carries one grid cell: species, index, last flag.
// ----------------------------------------------------------------------------
interface xrgf_out_if
  import xrgf_pkg::*;
;
  logic     valid;
  logic     ready;
  species_t species;
  index_t   cell_index;
  logic     last_cell;

  modport source (output valid, output species, output cell_index, output last_cell,
                  input ready);
  modport sink (input valid, input species, input cell_index, input last_cell,
                output ready);
endinterface

// ===== hdl/xrgf_draw.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xrgf_draw: xorshift draws and species pick for one cell
// Runs the alive draw, and for an alive cell the species draw, and returns
// the generator state left behind.
// ----------------------------------------------------------------------------
module xrgf_draw
  import xrgf_pkg::*;
#(
  parameter int unsigned NUM_SPECIES = 4
) (
  input  rng_state_t state_i,
  input  density_t   density_i,
  output rng_state_t state_o,
  output species_t   species_o
);

  localparam int unsigned ProdW = StateW + SpeciesW;
  localparam species_t    NumSp = SpeciesW'(NUM_SPECIES);

  function automatic rng_state_t xs32(input rng_state_t a);
    rng_state_t s;
    s = a ^ (a << 13);
    s = s ^ (s >> 17);
    s = s ^ (s << 5);
    return s;
  endfunction

  rng_state_t          s1;
  rng_state_t          s2;
  rng_state_t          u1;
  rng_state_t          u2;
  logic                alive;
  logic [ProdW-1:0]    prod;
  logic [SpeciesW:0]   pick;

  always_comb begin
    s1    = xs32(state_i);
    u1    = (state_i + s1) ^ DrawFlip;
    alive = {1'b0, u1} < density_i;
    s2    = xs32(s1);
    u2    = (s1 + s2) ^ DrawFlip;
    prod  = {{SpeciesW{1'b0}}, u2} * {{StateW{1'b0}}, NumSp};
    pick  = {1'b0, prod[ProdW-1:StateW]} + {{SpeciesW{1'b0}}, 1'b1};
    if (!alive) begin
      state_o   = s1;
      species_o = '0;
    end else begin
      state_o   = s2;
      // clamp to the top label
      species_o = (pick > {1'b0, NumSp}) ? NumSp : pick[SpeciesW-1:0];
    end
  end

endmodule

// ===== hdl/xorshift_random_grid_fill.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xorshift_random_grid_fill: uniform random fill of a cubic grid
// The cell for a tick is registered and valid on out_o in the cycle after its transfer.
// Throughput: one tick per cycle while the result is not stalled; the generator
// state feedback (two xorshift rounds, add, compare and species multiply) closes within that cycle.
// A stalled result holds in the output register and blocks new ticks.
// Reset clears generator, counters and output valid; seed and density go to
// zero and grid size to one.
// ----------------------------------------------------------------------------
module xorshift_random_grid_fill
  import xrgf_pkg::*;
#(
  parameter int unsigned NUM_SPECIES = 4,
  parameter int unsigned MAX_DIM     = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  xrgf_in_if.sink             in_i,
  xrgf_out_if.source          out_o
);

  localparam logic [EdgeW-1:0] MaxEdge = EdgeW'(MAX_DIM);

  // configuration
  rng_state_t           seed_q;
  density_t             density_q;
  logic [EdgeW-1:0]     edge_q, edge_d;
  logic [EdgeSqW-1:0]   edge_sq_q, edge_sq_d;

  // walk state
  rng_state_t           rng_q;
  logic [CountW-1:0]    x_q, y_q, z_q;
  index_t               row_q, plane_q;

  // output register
  logic                 out_valid_q;
  species_t             species_q;
  index_t               index_q;
  logic                 last_q;

  logic                 in_fire;
  rng_state_t           rng_cur, rng_d;
  logic [CountW-1:0]    x_cur, y_cur, z_cur, x_d, y_d, z_d;
  index_t               row_cur, plane_cur, row_d, plane_d;
  logic [CountW-1:0]    top;
  logic                 xl, yl, zl;
  species_t             species_d;
  index_t               index_d;

  assign in_i.ready       = !out_valid_q || out_o.ready;
  assign in_fire          = in_i.valid && in_i.ready;
  assign out_o.valid      = out_valid_q;
  assign out_o.species    = species_q;
  assign out_o.cell_index = index_q;
  assign out_o.last_cell  = last_q;

  // clamp grid size to 1..MAX_DIM
  always_comb begin
    priority if (cfg_data_i[EdgeW-1:0] == '0) begin
      edge_d = EdgeW'(1);
    end else if (cfg_data_i[EdgeW-1:0] > MaxEdge) begin
      edge_d = MaxEdge;
    end else begin
      edge_d = cfg_data_i[EdgeW-1:0];
    end
    edge_sq_d = {{(EdgeSqW-EdgeW){1'b0}}, edge_d} * {{(EdgeSqW-EdgeW){1'b0}}, edge_d};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q    <= '0;
      density_q <= '0;
      edge_q    <= EdgeW'(1);
      edge_sq_q <= EdgeSqW'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SEED_VALUE:       seed_q    <= cfg_data_i[StateW-1:0];
        CFG_DENSITY_FRACTION: density_q <= cfg_data_i;
        CFG_GRID_SIZE: begin
          edge_q    <= edge_d;
          edge_sq_q <= edge_sq_d;
        end
        default: ;
      endcase
    end
  end

  // restart reseeds and starts at cell zero
  always_comb begin
    if (in_i.restart) begin
      rng_cur   = seed_q + SeedOffset;
      x_cur     = '0;
      y_cur     = '0;
      z_cur     = '0;
      row_cur   = '0;
      plane_cur = '0;
    end else begin
      rng_cur   = rng_q;
      x_cur     = x_q;
      y_cur     = y_q;
      z_cur     = z_q;
      row_cur   = row_q;
      plane_cur = plane_q;
    end
  end

  xrgf_draw #(
    .NUM_SPECIES (NUM_SPECIES)
  ) u_draw (
    .state_i   (rng_cur),
    .density_i (density_q),
    .state_o   (rng_d),
    .species_o (species_d)
  );

  // advance z fastest, then y, then x
  always_comb begin
    top     = CountW'(edge_q - EdgeW'(1));
    zl      = z_cur >= top;
    yl      = y_cur >= top;
    xl      = x_cur >= top;
    index_d = plane_cur + row_cur + {{(IndexW-CountW){1'b0}}, x_cur};
    x_d     = x_cur;
    y_d     = y_cur;
    z_d     = z_cur;
    row_d   = row_cur;
    plane_d = plane_cur;
    if (!zl) begin
      z_d     = z_cur + CountW'(1);
      plane_d = plane_cur + {{(IndexW-EdgeSqW){1'b0}}, edge_sq_q};
    end else begin
      z_d     = '0;
      plane_d = '0;
      if (!yl) begin
        y_d   = y_cur + CountW'(1);
        row_d = row_cur + {{(IndexW-EdgeW){1'b0}}, edge_q};
      end else begin
        y_d   = '0;
        row_d = '0;
        x_d   = xl ? '0 : x_cur + CountW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rng_q       <= '0;
      x_q         <= '0;
      y_q         <= '0;
      z_q         <= '0;
      row_q       <= '0;
      plane_q     <= '0;
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      rng_q       <= rng_d;
      x_q         <= x_d;
      y_q         <= y_d;
      z_q         <= z_d;
      row_q       <= row_d;
      plane_q     <= plane_d;
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      species_q <= species_d;
      index_q   <= index_d;
      last_q    <= xl && yl && zl;
    end
  end

  // a restart transfer always yields cell zero
  a_restart_cell_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_i.restart |=> index_q == '0)
    else $error("restart did not start at cell zero");

  // species label stays within range
  a_species_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> species_q <= SpeciesW'(NUM_SPECIES))
    else $error("species label out of range");

  // zero density never yields a live cell
  a_zero_density: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && density_q == '0 |=> species_q == '0)
    else $error("live cell with zero density");

  // a stalled result blocks new ticks
  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_o.ready |-> !in_i.ready)
    else $error("tick taken while result stalled");

  // the last cell flag only shows with the top counters wrapping to zero
  a_last_wraps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && !in_i.restart && xl && yl && zl |=> x_q == '0 && y_q == '0 && z_q == '0)
    else $error("counters did not wrap after last cell");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the xorshift random grid fill
// Drives restart ticks through the input channel and predicts every grid cell
// (species draw, flat index, last flag) with a local copy of the generator,
// counters and registers. Register settings change between drained phases.
// The sender and receiver idle at random, and one long receiver hold-off
// backs the block up.
// ----------------------------------------------------------------------------
module tb;
  import xrgf_pkg::*;

  localparam int unsigned NumSpecies = 4;
  localparam int unsigned MaxDim     = 256;
  localparam logic [CfgIdxW-1:0] CfgIdxUnused = 2'd3;
  localparam int unsigned RandPhases = 9;
  localparam int unsigned PhaseTicks = 61;

  typedef struct packed {
    species_t species;
    index_t   cell_index;
    logic     last_cell;
  } grid_cell_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  xrgf_in_if  tick_if ();
  xrgf_out_if cell_if ();

  xorshift_random_grid_fill #(
    .NUM_SPECIES(NumSpecies),
    .MAX_DIM    (MaxDim)
  ) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_i      (tick_if),
    .out_o     (cell_if)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Shadow registers and generator/counter state of the fill.
  rng_state_t seed_reg;
  density_t   density_reg;
  logic [8:0] grid_reg;
  rng_state_t gen_state;
  logic [7:0] x_cnt, y_cnt, z_cnt;
  index_t     row_off, plane_off;

  logic         tick_queue[$];
  grid_cell_t   expected_cells[$];
  int unsigned  error_count = 0;
  int unsigned  send_idle_pct = 16;
  int unsigned  recv_idle_pct = 52;
  logic         tick_xfer = 1'b0;
  logic         hold_go = 1'b0;
  logic         hold_active = 1'b0;

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  function automatic rng_state_t take_draw();
    rng_state_t prev;
    rng_state_t s;
    prev = gen_state;
    s = prev;
    s ^= s << 13;
    s ^= s >> 17;
    s ^= s << 5;
    gen_state = s;
    return (prev + s) ^ DrawFlip;
  endfunction

  function automatic grid_cell_t fill_cell(logic restart);
    logic [8:0]  edge_n;
    logic [8:0]  top;
    logic        zl, yl, xl;
    logic [63:0] prod;
    logic [31:0] sp;
    grid_cell_t  c;
    edge_n = (grid_reg == 9'd0) ? 9'd1 : ((grid_reg > MaxDim) ? 9'(MaxDim) : grid_reg);
    top = edge_n - 9'd1;
    if (restart) begin
      gen_state = seed_reg + SeedOffset;
      x_cnt = '0;
      y_cnt = '0;
      z_cnt = '0;
      row_off = '0;
      plane_off = '0;
    end
    c.species = '0;
    if (density_t'(take_draw()) < density_reg) begin
      prod = 64'(take_draw()) * 64'(NumSpecies);
      sp = prod[63:32] + 32'd1;
      if (sp > NumSpecies) sp = NumSpecies;
      c.species = species_t'(sp);
    end
    zl = z_cnt >= top;
    yl = y_cnt >= top;
    xl = x_cnt >= top;
    c.cell_index = plane_off + row_off + index_t'(x_cnt);
    c.last_cell = xl && yl && zl;
    // z runs fastest, then y, then x
    if (!zl) begin
      z_cnt = z_cnt + 8'd1;
      plane_off = plane_off + index_t'(edge_n) * index_t'(edge_n);
    end else begin
      z_cnt = '0;
      plane_off = '0;
      if (!yl) begin
        y_cnt = y_cnt + 8'd1;
        row_off = row_off + index_t'(edge_n);
      end else begin
        y_cnt = '0;
        row_off = '0;
        x_cnt = xl ? 8'd0 : x_cnt + 8'd1;
      end
    end
    return c;
  endfunction

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_SEED_VALUE:       seed_reg = value[31:0];
      CFG_DENSITY_FRACTION: density_reg = value;
      CFG_GRID_SIZE:        grid_reg = value[8:0];
      default: ;
    endcase
  endtask

  // Hold until no tick is pending or offered and no cell is outstanding;
  // check again after the settle cycles to catch a tick taken late.
  task automatic wait_drained();
    do begin
      while (tick_queue.size() != 0 || tick_if.valid || expected_cells.size() != 0 ||
             cell_if.valid)
        @(negedge clk_i);
      repeat (2) @(negedge clk_i);
    end while (tick_queue.size() != 0 || tick_if.valid || expected_cells.size() != 0 ||
               cell_if.valid);
  endtask

  task automatic push_ticks(int unsigned count, int unsigned first_pct, int unsigned rest_pct);
    for (int unsigned i = 0; i < count; i++)
      tick_queue.push_back($urandom_range(99, 0) < ((i == 0) ? first_pct : rest_pct));
  endtask

  // Sender: offer the next pending tick once the current one has transferred.
  always @(negedge clk_i) begin
    if (rst_ni && (!tick_if.valid || tick_xfer)) begin
      if (tick_queue.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
        tick_if.valid <= 1'b1;
        tick_if.restart <= tick_queue.pop_front();
      end else begin
        tick_if.valid <= 1'b0;
        tick_if.restart <= 1'($urandom_range(1, 0));
      end
    end
  end

  always @(negedge clk_i) begin
    cell_if.ready <= !hold_active && ($urandom_range(99, 0) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin : cell_check
    grid_cell_t want;
    if (rst_ni) begin
      tick_xfer <= tick_if.valid && tick_if.ready;
      if (tick_if.valid && tick_if.ready)
        expected_cells.push_back(fill_cell(tick_if.restart));
      if (cell_if.valid && cell_if.ready) begin
        if (expected_cells.size() == 0) begin
          report_mismatch($sformatf("cell %0d with nothing outstanding", cell_if.cell_index));
        end else begin
          want = expected_cells.pop_front();
          if (cell_if.species !== want.species)
            report_mismatch($sformatf("species got %0d expected %0d",
                                      cell_if.species, want.species));
          if (cell_if.cell_index !== want.cell_index)
            report_mismatch($sformatf("cell_index got %0d expected %0d",
                                      cell_if.cell_index, want.cell_index));
          if (cell_if.last_cell !== want.last_cell)
            report_mismatch($sformatf("last_cell got %0d expected %0d at index %0d",
                                      cell_if.last_cell, want.last_cell, want.cell_index));
        end
      end
    end
  end

  // Long receiver hold-off while the sender keeps offering ticks.
  initial begin : receiver_hold
    wait (hold_go);
    @(negedge clk_i);
    hold_active <= 1'b1;
    repeat (64) @(negedge clk_i);
    hold_active <= 1'b0;
  end

  initial begin : watchdog
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin : stimulus
    logic [CfgDataW-1:0] dens;
    logic [8:0]          grid;
    logic [31:0]         seed;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    tick_if.valid = 1'b0;
    tick_if.restart = 1'b0;
    cell_if.ready = 1'b0;
    seed_reg = '0;
    density_reg = '0;
    grid_reg = 9'd1;
    gen_state = '0;
    x_cnt = '0;
    y_cnt = '0;
    z_cnt = '0;
    row_off = '0;
    plane_off = '0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Unseeded until the restart on the fourth tick: each draw before it is one half,
    // so a density just above it makes those cells alive with species three.
    write_reg(CFG_DENSITY_FRACTION, 33'h0_8000_0001);
    write_reg(CFG_GRID_SIZE, 33'd2);
    tick_queue = '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0};
    wait_drained();

    // Most negative seed, density at full scale, grid size zero.
    write_reg(CFG_SEED_VALUE, 33'h0_8000_0000);
    write_reg(CFG_DENSITY_FRACTION, 33'h1_0000_0000);
    write_reg(CFG_GRID_SIZE, 33'd0);
    tick_queue = '{1'b1, 1'b0, 1'b0};
    wait_drained();

    // Most positive seed, density above full scale, oversize grid.
    write_reg(CFG_SEED_VALUE, 33'h1_7FFF_FFFF);
    write_reg(CFG_DENSITY_FRACTION, 33'h1_FFFF_FFFF);
    write_reg(CFG_GRID_SIZE, 33'h1_FFFF_FFFF);
    tick_queue = '{1'b1, 1'b0, 1'b0};
    wait_drained();

    // Shrink the grid under running counters, never alive, ignored index.
    write_reg(CFG_DENSITY_FRACTION, 33'd0);
    write_reg(CFG_GRID_SIZE, 33'd3);
    write_reg(CfgIdxUnused, {1'b1, 32'($urandom)});
    tick_queue = '{1'b0, 1'b0, 1'b0, 1'b0};
    wait_drained();

    for (int unsigned ph = 0; ph < RandPhases; ph++) begin
      if (ph < 3) begin
        send_idle_pct = 16;
        recv_idle_pct = 52;
      end else if (ph < 6) begin
        send_idle_pct = 52;
        recv_idle_pct = 16;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case ($urandom_range(0, 7))
        0:       seed = 32'h8000_0000;
        1:       seed = 32'h7FFF_FFFF;
        default: seed = $urandom;
      endcase
      case ($urandom_range(0, 9))
        0:       dens = '0;
        1:       dens = 33'h1_0000_0000;
        2:       dens = 33'h1_FFFF_FFFF;
        3:       dens = {1'b1, 32'($urandom)};
        default: dens = {1'b0, 32'($urandom)};
      endcase
      case ($urandom_range(0, 9))
        0:       grid = 9'd0;
        1:       grid = 9'd256;
        2:       grid = 9'($urandom_range(257, 511));
        default: grid = 9'($urandom_range(1, 6));
      endcase
      write_reg(CFG_SEED_VALUE, {1'($urandom_range(1, 0)), seed});
      write_reg(CFG_DENSITY_FRACTION, dens);
      // keep the old size now and then so a run continues under a new seed
      if ($urandom_range(0, 4) != 0)
        write_reg(CFG_GRID_SIZE, {24'($urandom), grid});
      if ($urandom_range(0, 3) == 0)
        write_reg(CfgIdxUnused, {1'($urandom_range(1, 0)), 32'($urandom)});
      push_ticks(PhaseTicks, 85, 3);
      if (ph == 6) hold_go = 1'b1;
      wait_drained();
    end

    repeat (4) @(negedge clk_i);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
